// ===== sv/usdt_pkg.sv =====
package usdt_pkg;
    localparam int TableEntriesDefault = 16;
    localparam logic [15:0] FirstEphemeralPort = 16'd1024;
    localparam logic [15:0] UdpHeaderBytes = 16'd8;

    localparam logic [1:0] CMD_RECEIVE = 2'd0;
    localparam logic [1:0] CMD_CONNECT = 2'd1;
    localparam logic [1:0] CMD_LISTEN = 2'd2;
    localparam logic [1:0] CMD_DISCONNECT = 2'd3;

    localparam logic [2:0] ST_OK = 3'd0;
    localparam logic [2:0] ST_NO_MATCH = 3'd1;
    localparam logic [2:0] ST_SHORT = 3'd2;
    localparam logic [2:0] ST_FULL = 3'd3;
    localparam logic [2:0] ST_NO_ID = 3'd4;

    typedef struct packed {
        logic [15:0] local_port;
        logic [15:0] remote_port;
        logic [31:0] local_ip;
        logic [31:0] remote_ip;
        logic        listening;
        logic [15:0] id;
    } t_entry;

    typedef struct packed {
        logic [31:0] source_ip;
        logic [31:0] dest_ip;
        logic [15:0] source_port;
        logic [15:0] dest_port;
    } t_key;
endpackage

// ===== sv/usdt_cell.sv =====
// One table slot. Entries rotate one slot toward index 0 each shift cycle,
// so the controller sees every entry at slot 0 in table order.
module usdt_cell
    import usdt_pkg::*;
(
    input  logic   i_clk,
    input  logic   i_load,
    input  t_entry i_load_entry,
    input  logic   i_shift,
    input  t_entry i_neighbor,
    output t_entry o_entry
);
    t_entry r_entry;

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_entry <= i_load_entry;
        end else if (i_shift) begin
            r_entry <= i_neighbor;
        end
    end

    assign o_entry = r_entry;
endmodule

// ===== sv/udp_socket_demux_table.sv =====
// Connect and listen pass from start through the DONE state to o_valid.
// Receive and disconnect also pass through SCAN, one full rotation of the
// cell ring, regardless of entry count. A new command is taken only while
// busy is low; busy stays high until the result strobe.
// Reset: count 0, next port 1024, next id 1, own_ip 0; slot contents undefined.
// The result strobe cannot be stalled by the receiver.
module udp_socket_demux_table
    import usdt_pkg::*;
#(
    parameter int TABLE_ENTRIES = TableEntriesDefault
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  i_command,
    input  logic [31:0] i_source_ip,
    input  logic [31:0] i_dest_ip,
    input  logic [15:0] i_source_port,
    input  logic [15:0] i_dest_port,
    input  logic [15:0] i_packet_length,
    input  logic [31:0] i_peer_ip,
    input  logic [15:0] i_port_arg,
    input  logic [15:0] i_target_id,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [31:0] i_cfg_data,
    output logic        o_valid,
    output logic [2:0]  o_status,
    output logic [15:0] o_socket_id,
    output logic [15:0] o_assigned_port,
    output logic [15:0] o_payload_length
);
    localparam int IW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam int CW = $clog2(TABLE_ENTRIES + 1);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_SCAN = 2'd1;
    localparam logic [1:0] S_DONE = 2'd2;

    logic [1:0]    r_state;
    logic [CW-1:0] r_count;
    logic [15:0]   r_next_port;
    logic [15:0]   r_next_id;
    logic [31:0]   r_own_ip;
    logic [CW-1:0] r_step;
    logic [1:0]    r_cmd;
    t_key          r_key;
    logic [15:0]   r_len;
    logic [15:0]   r_target;
    logic          r_found;
    logic [2:0]    r_status;
    logic [15:0]   r_sid;
    logic [15:0]   r_port;
    logic [15:0]   r_plen;
    t_entry        r_last;

    t_entry ring [TABLE_ENTRIES];
    logic   load [TABLE_ENTRIES];
    t_entry load_entry [TABLE_ENTRIES];
    logic   shift;

    logic   accept;
    logic   full;
    t_entry head;
    logic   valid_pos;
    logic   local_hit;
    logic   recv_hit;
    logic   disc_hit;
    t_entry head_new;
    t_entry created;

    assign accept = start && !busy;
    assign busy = r_state != S_IDLE;
    assign o_cfg_ready = r_state == S_IDLE;
    assign full = r_count == CW'(TABLE_ENTRIES);
    assign shift = r_state == S_SCAN;
    assign head = ring[0];

    // Position of the head entry in table order is r_step.
    assign valid_pos = r_step < r_count;
    assign local_hit = head.local_port == r_key.dest_port && head.local_ip == r_key.dest_ip;
    assign recv_hit = valid_pos && !r_found && r_len >= UdpHeaderBytes && local_hit &&
        (head.listening || (head.remote_port == r_key.source_port &&
                            head.remote_ip == r_key.source_ip));
    assign disc_hit = valid_pos && !r_found && r_target != 16'd0 && head.id == r_target;

    always_comb begin
        head_new = head;
        if (r_cmd == CMD_RECEIVE && recv_hit && head.listening) begin
            head_new.listening = 1'b0;
            head_new.remote_port = r_key.source_port;
            head_new.remote_ip = r_key.source_ip;
        end
        if (r_cmd == CMD_DISCONNECT && disc_hit) begin
            head_new = r_last;
        end
        created.local_port = (i_command == CMD_CONNECT) ? r_next_port : i_port_arg;
        created.local_ip = r_own_ip;
        created.remote_port = (i_command == CMD_CONNECT) ? i_port_arg : 16'd0;
        created.remote_ip = (i_command == CMD_CONNECT) ? i_peer_ip : 32'd0;
        created.listening = i_command == CMD_LISTEN;
        created.id = r_next_id;
    end

    for (genvar g = 0; g < TABLE_ENTRIES; g++) begin : g_cell
        t_entry neighbor;
        if (g == TABLE_ENTRIES - 1) begin : g_wrap
            assign neighbor = head_new;
        end else begin : g_mid
            assign neighbor = ring[g+1];
        end
        assign load[g] = accept && !full && (i_command == CMD_CONNECT ||
            i_command == CMD_LISTEN) && r_count == CW'(g);
        assign load_entry[g] = created;
        usdt_cell u_cell (
            .i_clk       (i_clk),
            .i_load      (load[g]),
            .i_load_entry(load_entry[g]),
            .i_shift     (shift),
            .i_neighbor  (neighbor),
            .o_entry     (ring[g])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
            r_next_port <= FirstEphemeralPort;
            r_next_id <= 16'd1;
            r_own_ip <= 32'd0;
            o_valid <= 1'b0;
        end else begin
            o_valid <= 1'b0;
            if (i_cfg_valid && o_cfg_ready) begin
                r_own_ip <= i_cfg_data;
            end
            case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        r_cmd <= i_command;
                        r_key <= '{i_source_ip, i_dest_ip, i_source_port, i_dest_port};
                        r_len <= i_packet_length;
                        r_target <= i_target_id;
                        r_step <= '0;
                        r_found <= 1'b0;
                        r_sid <= 16'd0;
                        r_port <= 16'd0;
                        r_plen <= 16'd0;
                        r_last <= ring[IW'(r_count - CW'(1))];
                        if (i_command == CMD_CONNECT || i_command == CMD_LISTEN) begin
                            r_state <= S_DONE;
                            if (full) begin
                                r_status <= ST_FULL;
                            end else begin
                                r_status <= ST_OK;
                                r_sid <= r_next_id;
                                r_port <= created.local_port;
                                r_count <= r_count + CW'(1);
                                r_next_id <= (r_next_id == 16'hFFFF) ? 16'd1
                                                                     : r_next_id + 16'd1;
                                if (i_command == CMD_CONNECT) begin
                                    r_next_port <= r_next_port + 16'd1;
                                end
                            end
                        end else begin
                            r_state <= S_SCAN;
                        end
                    end
                end
                S_SCAN: begin
                    r_step <= r_step + CW'(1);
                    if (r_cmd == CMD_RECEIVE && recv_hit) begin
                        r_found <= 1'b1;
                        r_sid <= head.id;
                        r_port <= head.local_port;
                        r_plen <= r_len - UdpHeaderBytes;
                    end
                    if (r_cmd == CMD_DISCONNECT && disc_hit) begin
                        r_found <= 1'b1;
                        r_sid <= r_target;
                        r_port <= head.local_port;
                    end
                    if (r_step == CW'(TABLE_ENTRIES - 1)) begin
                        r_state <= S_DONE;
                    end
                end
                S_DONE: begin
                    r_state <= S_IDLE;
                    o_valid <= 1'b1;
                    if (r_cmd == CMD_RECEIVE) begin
                        r_status <= r_len < UdpHeaderBytes ? ST_SHORT
                                  : (r_found ? ST_OK : ST_NO_MATCH);
                    end else if (r_cmd == CMD_DISCONNECT) begin
                        r_status <= r_found ? ST_OK : ST_NO_ID;
                        if (r_found) begin
                            r_count <= r_count - CW'(1);
                        end
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    always_comb begin
        o_status = r_status;
        o_socket_id = r_sid;
        o_assigned_port = r_port;
        o_payload_length = r_plen;
        if (r_cmd == CMD_RECEIVE || r_cmd == CMD_DISCONNECT) begin
            if (!r_found) begin
                o_status = (r_cmd == CMD_DISCONNECT) ? ST_NO_ID
                         : (r_len < UdpHeaderBytes ? ST_SHORT : ST_NO_MATCH);
            end else begin
                o_status = ST_OK;
            end
        end
    end

`ifndef SYNTH
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(TABLE_ENTRIES)) else $error("entry count overflow");
    a_valid_pulse: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |=> !o_valid) else $error("result strobe held");
    a_busy_cfg: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        busy |-> !o_cfg_ready) else $error("config open while busy");
    a_id_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_next_id != 16'd0) else $error("id zero allocated");
    a_hit_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DONE && r_cmd == CMD_DISCONNECT && r_found) |-> r_count != '0)
        else $error("disconnect on empty table");
`endif
endmodule
